// File: hdl/pli_pkg.sv
package pli_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int DivSteps  = 32;
  localparam int StepW     = $clog2(DivSteps);

  localparam logic KindLoad = 1'b0;
  localparam logic KindEval = 1'b1;

  localparam logic CfgAxisSelect = 1'b0;
  localparam logic CfgPointCount = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/pli_store.sv
module pli_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [pli_pkg::IdxW-1:0]       waddr_i,
  input  logic signed [31:0]             wpos_i,
  input  logic signed [31:0]             wval_i,
  input  logic [pli_pkg::IdxW-1:0]       raddr_i,
  output logic signed [31:0]             rpos_o,
  output logic signed [31:0]             rval_o
);

  logic signed [31:0] pos_mem [pli_pkg::MaxPoints];
  logic signed [31:0] val_mem [pli_pkg::MaxPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pos_mem[waddr_i] <= wpos_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rpos_o <= pos_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

// File: hdl/pli_div.sv
module pli_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          dividend_i,
  input  logic [31:0]          divisor_i,
  output logic [31:0]          quot_o,
  output pli_pkg::div_status_t status_o
);

  logic [31:0]                rem_q, rem_d;
  logic [31:0]                lo_q, lo_d;
  logic [31:0]                dvs_q, dvs_d;
  logic [pli_pkg::StepW-1:0]  step_q, step_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [32:0]                trial;
  logic [32:0]                diff;
  logic                       ge;

  assign trial = {rem_q, lo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[63:32];
      lo_d   = dividend_i[31:0];
      dvs_d  = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[31:0] : trial[31:0];
      lo_d   = {lo_q[30:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == pli_pkg::StepW'(pli_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
  end

  assign quot_o        = lo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: hdl/piecewise_linear_interpolator.sv
// Load beat: accepted while idle, writes one breakpoint, gives no result.
// Evaluate beat: a result at or below slot 0's position is clamped to its value, else one at
// or above the last slot's position to that value; an interior result comes from a scan of
// the single table read port (one slot a cycle) from slot 1 and then the 32-step divider.
// One beat at a time; in_stall_o is high until the result is in the output register.
// Reset clears the control state, axis_select to 0 and point_count to 1; the table is not cleared.
module piecewise_linear_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [3:0]         point_index_i,
  input  logic signed [31:0] knot_position_i,
  input  logic signed [31:0] knot_value_i,
  input  logic signed [31:0] x_arg_i,
  input  logic signed [31:0] y_arg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o
);

  localparam int IdxW = pli_pkg::IdxW;
  localparam int CntW = pli_pkg::CntW;

  pli_pkg::state_e      state_q, state_d;
  pli_pkg::div_status_t div_st;

  logic                 axis_sel_q;
  logic [4:0]           point_count_q;
  logic [CntW-1:0]      n_active;
  logic [IdxW-1:0]      last_idx;

  logic signed [31:0]   z_q;
  logic signed [31:0]   prev_p_q, prev_v_q;
  logic signed [31:0]   res_q;
  logic [IdxW-1:0]      idx_q;
  logic [31:0]          absdv_q, dz_q, den_q;
  logic                 neg_q;
  logic                 out_valid_q;
  logic signed [31:0]   out_data_q;

  logic                 mem_we;
  logic                 slot_ok;
  logic [IdxW-1:0]      rd_addr;
  logic signed [31:0]   rd_pos, rd_val;
  logic                 eval_acc;
  logic                 div_start;
  logic                 out_load;
  logic                 can_load;
  logic                 scan_more;
  logic [31:0]          quot;
  logic [63:0]          product;

  logic signed [32:0]   dv_w, dz_w, den_w;
  logic [32:0]          absdv_w;
  logic signed [33:0]   sum_w;
  logic signed [31:0]   sat_w;

  always_comb begin
    if (point_count_q == '0) begin
      n_active = CntW'(1);
    end else if (32'(point_count_q) > pli_pkg::MaxPoints) begin
      n_active = CntW'(pli_pkg::MaxPoints);
    end else begin
      n_active = CntW'(point_count_q);
    end
  end
  assign last_idx = IdxW'(n_active - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_sel_q    <= 1'b0;
      point_count_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pli_pkg::CfgAxisSelect: axis_sel_q    <= cfg_data_i[0];
        pli_pkg::CfgPointCount: point_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign slot_ok   = 32'(point_index_i) < pli_pkg::MaxPoints;
  assign eval_acc  = (state_q == pli_pkg::S_IDLE) && in_valid_i && (kind_i == pli_pkg::KindEval);
  assign scan_more = (idx_q < last_idx) && (rd_pos < z_q);
  assign can_load  = !out_valid_q || !out_stall_i;

  pli_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IdxW'(point_index_i)),
    .wpos_i  (knot_position_i),
    .wval_i  (knot_value_i),
    .raddr_i (rd_addr),
    .rpos_o  (rd_pos),
    .rval_o  (rd_val)
  );

  assign product = 64'(absdv_q) * 64'(dz_q);

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (den_q),
    .quot_o     (quot),
    .status_o   (div_st)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      pli_pkg::S_IDLE:  if (eval_acc) state_d = pli_pkg::S_FIRST;
      pli_pkg::S_FIRST: state_d = (z_q <= rd_pos) ? pli_pkg::S_DONE : pli_pkg::S_LAST;
      pli_pkg::S_LAST:  state_d = (z_q >= rd_pos) ? pli_pkg::S_DONE : pli_pkg::S_SCAN;
      pli_pkg::S_SCAN:  if (!scan_more) state_d = pli_pkg::S_DIFF;
      pli_pkg::S_DIFF:  state_d = pli_pkg::S_MUL;
      pli_pkg::S_MUL:   state_d = pli_pkg::S_DIV;
      pli_pkg::S_DIV:   if (div_st.done) state_d = pli_pkg::S_DONE;
      pli_pkg::S_DONE:  if (can_load) state_d = pli_pkg::S_IDLE;
      default:          state_d = pli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    rd_addr    = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      pli_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        mem_we     = in_valid_i && (kind_i == pli_pkg::KindLoad) && slot_ok;
      end
      pli_pkg::S_FIRST: rd_addr = last_idx;
      pli_pkg::S_LAST:  rd_addr = IdxW'(1);
      pli_pkg::S_SCAN:  rd_addr = idx_q + 1'b1;
      pli_pkg::S_MUL:   div_start = 1'b1;
      pli_pkg::S_DONE:  out_load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pli_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign dv_w    = 33'(rd_val) - 33'(prev_v_q);
  assign dz_w    = 33'(z_q) - 33'(prev_p_q);
  assign den_w   = 33'(rd_pos) - 33'(prev_p_q);
  assign absdv_w = dv_w[32] ? 33'(-dv_w) : 33'(dv_w);

  assign sum_w = neg_q ? (34'(prev_v_q) - $signed({2'b00, quot}))
                       : (34'(prev_v_q) + $signed({2'b00, quot}));

  always_comb begin
    if (sum_w > 34'sh0_7FFF_FFFF) begin
      sat_w = 32'sh7FFF_FFFF;
    end else if (sum_w < -34'sh0_8000_0000) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pli_pkg::S_IDLE: begin
        if (eval_acc) z_q <= axis_sel_q ? y_arg_i : x_arg_i;
      end
      pli_pkg::S_FIRST: begin
        prev_p_q <= rd_pos;
        prev_v_q <= rd_val;
        res_q    <= rd_val;
      end
      pli_pkg::S_LAST: begin
        res_q <= rd_val;
        idx_q <= IdxW'(1);
      end
      pli_pkg::S_SCAN: begin
        if (scan_more) begin
          prev_p_q <= rd_pos;
          prev_v_q <= rd_val;
          idx_q    <= idx_q + 1'b1;
        end else begin
          neg_q   <= dv_w[32];
          absdv_q <= absdv_w[31:0];
          dz_q    <= dz_w[31:0];
          den_q   <= (den_w[32] || den_w == '0) ? 32'd1 : den_w[31:0];
        end
      end
      pli_pkg::S_DIV: begin
        if (div_st.done) res_q <= sat_w;
      end
      pli_pkg::S_DONE: begin
        if (out_load) out_data_q <= res_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_div_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pli_pkg::S_DIV) |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle divider");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pli_pkg::S_SCAN) |-> (idx_q != '0 && idx_q <= last_idx))
    else $error("scan index out of range");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pli_pkg::S_DONE && out_valid_q && out_stall_i) |=>
      (state_q == pli_pkg::S_DONE))
    else $error("result dropped while output stalled");

endmodule
